>>> rtl/core/vsd_pkg.sv
// Package with the constants, register codes and controller states of the soft Viterbi decoder.
package vsd_pkg;

	localparam int MAX_CONSTRAINT_DEF = 7;
	localparam int MAX_FRAME_DEF      = 64;
	localparam int MAX_OUTPUTS_DEF    = 4;
	localparam int SOFT_WIDTH_DEF     = 8;

	localparam int NUM_SOFT   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int GEN_W      = 7;
	localparam int KLEN_W     = 3;
	localparam int METRIC_W   = 24;
	localparam int ONE_LEVEL  = 32;

	localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GEN0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GEN1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GEN2       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GEN3       = 3'd5;

	localparam logic [KLEN_W-1:0] RST_CONSTRAINT = 3'd7;
	localparam logic [KLEN_W-1:0] RST_COUNT      = 3'd2;
	localparam logic [GEN_W-1:0]  RST_GEN0       = 7'd121;
	localparam logic [GEN_W-1:0]  RST_GEN1       = 7'd91;
	localparam logic [GEN_W-1:0]  RST_GEN2       = 7'd0;
	localparam logic [GEN_W-1:0]  RST_GEN3       = 7'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ACS,
		ST_FINISH,
		ST_SEARCH,
		ST_TRACE_RD,
		ST_TRACE_USE,
		ST_EMIT
	} vsd_state_t;

endpackage

>>> rtl/core/viterbi_soft_decoder.sv
// Soft-decision Viterbi decoder for rate 1/n convolutional codes with memory-held path metrics.
// Each accepted beat is one trellis step. A step that fits in the frame is handled in order: the
// soft samples are squared, then one add-compare-select per state per cycle runs against the
// path metric memory (two reads from the old bank, one write to the new bank), and then the
// survivor word is stored before the next ready. Steps beyond MAX_FRAME are dropped. The beat
// marked last is followed by a best-state search over the metric memory, a traceback through
// the survivor memory, and then one output beat per bit in frame order, the final one with
// frame_end set. No input is taken from the last beat until the final output beat. The metric
// memory needs no clearing pass: on the first step of a frame only state zero is reachable and
// its metric is taken as zero. Configuration must be written by the user only while idle; the
// block itself does not enforce it.
module viterbi_soft_decoder #(
	parameter int MAX_CONSTRAINT = vsd_pkg::MAX_CONSTRAINT_DEF,
	parameter int MAX_FRAME      = vsd_pkg::MAX_FRAME_DEF,
	parameter int MAX_OUTPUTS    = vsd_pkg::MAX_OUTPUTS_DEF,
	parameter int SOFT_WIDTH     = vsd_pkg::SOFT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vsd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SOFT_WIDTH-1:0]        soft_0,
	input  logic signed [SOFT_WIDTH-1:0]        soft_1,
	input  logic signed [SOFT_WIDTH-1:0]        soft_2,
	input  logic signed [SOFT_WIDTH-1:0]        soft_3,
	input  logic                                last_step,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                decoded_bit,
	output logic                                frame_end
);
	import vsd_pkg::*;

	localparam int SB   = MAX_CONSTRAINT - 1;
	localparam int NS   = 1 << SB;
	localparam int KBW  = $clog2(SB);
	localparam int FW   = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int CW   = $clog2(MAX_FRAME + 1);
	localparam int DW   = ((SOFT_WIDTH > 7) ? SOFT_WIDTH : 7) + 1;
	localparam int SQW  = 2 * DW;
	localparam int BMW  = SQW + 2;
	localparam int TW   = ((BMW > METRIC_W) ? BMW : METRIC_W) + 1;

	vsd_state_t state_q, state_d;

	logic [KLEN_W-1:0] klen_q;
	logic [KLEN_W-1:0] ncount_q;
	logic [GEN_W-1:0]  gen_q [NUM_SOFT];

	logic signed [SOFT_WIDTH-1:0] rx_q [NUM_SOFT];
	logic                         last_q;
	logic [SQW-1:0]               sq_pos_q [NUM_SOFT];
	logic [SQW-1:0]               sq_neg_q [NUM_SOFT];

	logic [CW-1:0] step_count_q;
	logic [NS-1:0] reach_q, nreach_q, dec_q;
	logic          bank_q;
	logic [SB:0]   i_q;

	logic [METRIC_W-1:0] pm_mem [2*NS];
	logic [METRIC_W-1:0] rd_a_q, rd_b_q;
	logic [SB:0]         pm_raddr_a, pm_raddr_b, pm_waddr;
	logic                pm_we;
	logic [METRIC_W-1:0] pm_wdata;

	logic [NS-1:0] surv_mem [MAX_FRAME];
	logic [NS-1:0] surv_rd_q;

	logic                acs_v_s1, srch_v_s1, fresh_s1, r0_s1, r1_s1;
	logic [SB-1:0]       ns_s1;
	logic [BMW-1:0]      bm0_s1, bm1_s1;
	logic                found_q;
	logic [SB-1:0]       best_q;
	logic [METRIC_W-1:0] best_m_q;

	logic [FW-1:0]        t_q, e_q;
	logic [SB-1:0]        st_q;
	logic [MAX_FRAME-1:0] out_bits_q;

	logic [KLEN_W-1:0] k_eff, n_eff;
	logic [SB:0]       states_cnt;
	logic [SB-1:0]     smask, ns_i, s0_i, s1_i;
	logic [KBW-1:0]    kb;
	logic              issue, inbit;
	logic [BMW-1:0]    bm0_i, bm1_i;
	logic [TW-1:0]     tot0, tot1;
	logic [METRIC_W-1:0] m0, m1, sat0, sat1;
	logic              pick1;
	logic [FW-1:0]     last_idx;

	always_comb begin
		k_eff = klen_q;
		if (klen_q < KLEN_W'(2)) k_eff = KLEN_W'(2);
		else if (klen_q > KLEN_W'(MAX_CONSTRAINT)) k_eff = KLEN_W'(MAX_CONSTRAINT);
		n_eff = ncount_q;
		if (ncount_q < KLEN_W'(2)) n_eff = KLEN_W'(2);
		else if (ncount_q > KLEN_W'(MAX_OUTPUTS)) n_eff = KLEN_W'(MAX_OUTPUTS);
		states_cnt = (SB+1)'(1) << (k_eff - KLEN_W'(1));
		smask      = SB'(states_cnt - (SB+1)'(1));
		kb         = KBW'(k_eff - KLEN_W'(2));
		last_idx   = FW'(step_count_q - CW'(1));
	end

	assign issue = (i_q != states_cnt);
	assign ns_i  = i_q[SB-1:0];
	assign inbit = ns_i[kb];
	assign s0_i  = (ns_i << 1) & smask;
	assign s1_i  = s0_i | SB'(1);

	always_comb begin
		logic [MAX_CONSTRAINT-1:0] w0, w1, ib;
		ib = MAX_CONSTRAINT'(inbit) << (k_eff - KLEN_W'(1));
		w0 = ib | MAX_CONSTRAINT'(s0_i);
		w1 = ib | MAX_CONSTRAINT'(s1_i);
		bm0_i = '0;
		bm1_i = '0;
		for (int g = 0; g < NUM_SOFT; g++) begin
			if (KLEN_W'(g) < n_eff) begin
				bm0_i = bm0_i + BMW'((^(gen_q[g][MAX_CONSTRAINT-1:0] & w0)) ?
					sq_pos_q[g] : sq_neg_q[g]);
				bm1_i = bm1_i + BMW'((^(gen_q[g][MAX_CONSTRAINT-1:0] & w1)) ?
					sq_pos_q[g] : sq_neg_q[g]);
			end
		end
	end

	always_comb begin
		m0    = fresh_s1 ? '0 : rd_a_q;
		m1    = fresh_s1 ? '0 : rd_b_q;
		tot0  = TW'(m0) + TW'(bm0_s1);
		tot1  = TW'(m1) + TW'(bm1_s1);
		sat0  = (tot0 > TW'(METRIC_MAX)) ? METRIC_MAX : tot0[METRIC_W-1:0];
		sat1  = (tot1 > TW'(METRIC_MAX)) ? METRIC_MAX : tot1[METRIC_W-1:0];
		pick1 = r1_s1 && (!r0_s1 || (sat1 < sat0));
	end

	always_comb begin
		pm_raddr_a = {bank_q, s0_i};
		pm_raddr_b = {bank_q, s1_i};
		if (state_q == ST_SEARCH) pm_raddr_a = {bank_q, ns_i};
		pm_we    = acs_v_s1 && (r0_s1 || r1_s1);
		pm_waddr = {~bank_q, ns_s1};
		pm_wdata = pick1 ? sat1 : sat0;
	end

	always_ff @(posedge clk) begin
		if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
		rd_a_q <= pm_mem[pm_raddr_a];
		rd_b_q <= pm_mem[pm_raddr_b];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) surv_mem[step_count_q[FW-1:0]] <= dec_q;
		surv_rd_q <= surv_mem[t_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (step_count_q != CW'(MAX_FRAME)) state_d = ST_PREP;
					else if (last_step) state_d = ST_SEARCH;
				end
			end
			ST_PREP: state_d = ST_ACS;
			ST_ACS: begin
				if (!issue && !acs_v_s1) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = last_q ? ST_SEARCH : ST_IDLE;
			ST_SEARCH: begin
				if (!issue && !srch_v_s1) state_d = ST_TRACE_RD;
			end
			ST_TRACE_RD: state_d = ST_TRACE_USE;
			ST_TRACE_USE: begin
				if (t_q == '0) state_d = ST_EMIT;
				else state_d = ST_TRACE_RD;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && (e_q == last_idx)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q       <= RST_CONSTRAINT;
			ncount_q     <= RST_COUNT;
			gen_q[0]     <= RST_GEN0;
			gen_q[1]     <= RST_GEN1;
			gen_q[2]     <= RST_GEN2;
			gen_q[3]     <= RST_GEN3;
			step_count_q <= '0;
			reach_q      <= NS'(1);
			bank_q       <= 1'b0;
			i_q          <= '0;
			acs_v_s1     <= 1'b0;
			srch_v_s1    <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CONSTRAINT: klen_q   <= cfg_data[KLEN_W-1:0];
					REG_COUNT:      ncount_q <= cfg_data[KLEN_W-1:0];
					REG_GEN0:       gen_q[0] <= cfg_data;
					REG_GEN1:       gen_q[1] <= cfg_data;
					REG_GEN2:       gen_q[2] <= cfg_data;
					REG_GEN3:       gen_q[3] <= cfg_data;
					default: ;
				endcase
			end
			acs_v_s1  <= (state_q == ST_ACS) && issue;
			srch_v_s1 <= (state_q == ST_SEARCH) && issue;
			if ((state_q == ST_ACS || state_q == ST_SEARCH) && issue) i_q <= i_q + (SB+1)'(1);
			else if (state_q != ST_ACS && state_q != ST_SEARCH) i_q <= '0;
			if (state_q != ST_SEARCH) found_q <= 1'b0;
			else if (srch_v_s1 && reach_q[ns_s1]) found_q <= 1'b1;
			if (state_q == ST_FINISH) begin
				bank_q       <= ~bank_q;
				reach_q      <= nreach_q;
				step_count_q <= step_count_q + CW'(1);
			end
			if (state_q == ST_EMIT && out_ready && (e_q == last_idx)) begin
				step_count_q <= '0;
				reach_q      <= NS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rx_q[0] <= soft_0;
			rx_q[1] <= soft_1;
			rx_q[2] <= soft_2;
			rx_q[3] <= soft_3;
			last_q  <= last_step;
		end
		if (state_q == ST_PREP) begin
			for (int g = 0; g < NUM_SOFT; g++) begin
				logic signed [DW-1:0] dp, dn;
				logic signed [SQW-1:0] pp, pn;
				dp = DW'(rx_q[g]) - DW'(ONE_LEVEL);
				dn = DW'(rx_q[g]) + DW'(ONE_LEVEL);
				pp = dp * dp;
				pn = dn * dn;
				sq_pos_q[g] <= pp;
				sq_neg_q[g] <= pn;
			end
			nreach_q <= '0;
			dec_q    <= '0;
		end
		if (state_q == ST_ACS) begin
			ns_s1    <= ns_i;
			bm0_s1   <= bm0_i;
			bm1_s1   <= bm1_i;
			r0_s1    <= reach_q[s0_i];
			r1_s1    <= reach_q[s1_i];
			fresh_s1 <= (step_count_q == '0);
		end
		if (state_q == ST_SEARCH) ns_s1 <= ns_i;
		if (acs_v_s1) begin
			nreach_q[ns_s1] <= r0_s1 | r1_s1;
			dec_q[ns_s1]    <= pick1;
		end
		if (state_q != ST_SEARCH) begin
			best_q   <= '0;
			best_m_q <= '0;
		end else if (srch_v_s1 && reach_q[ns_s1] && (!found_q || rd_a_q < best_m_q)) begin
			best_q   <= ns_s1;
			best_m_q <= rd_a_q;
		end
		if (state_q == ST_SEARCH && !issue && !srch_v_s1) begin
			t_q  <= last_idx;
			st_q <= best_q;
		end
		if (state_q == ST_TRACE_USE) begin
			out_bits_q[t_q] <= st_q[kb];
			st_q <= ((st_q << 1) & smask) | SB'(surv_rd_q[st_q]);
			t_q  <= t_q - FW'(1);
			e_q  <= '0;
		end
		if (state_q == ST_EMIT && out_ready) e_q <= e_q + FW'(1);
	end

	assign decoded_bit = out_bits_q[e_q];
	assign frame_end   = (e_q == last_idx);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output beats offered together");

	a_acs_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		acs_v_s1 |-> (state_q == ST_ACS))
		else $error("compare stage active outside a trellis step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_count_q <= CW'(MAX_FRAME))
		else $error("step count beyond frame capacity");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && frame_end) |=> (step_count_q == '0 && reach_q == NS'(1)))
		else $error("trellis not cleared after frame end");
`endif

endmodule

>>> test/viterbi_checker.sv
// Checker for the soft Viterbi decoder: predicts decoded bits from the observed beats and compares.
`timescale 1ns / 1ps
module viterbi_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic signed [7:0] soft_0,
	input  logic signed [7:0] soft_1,
	input  logic signed [7:0] soft_2,
	input  logic signed [7:0] soft_3,
	input  logic              last_step,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              decoded_bit,
	input  logic              frame_end,
	output int                pending,
	output int                errors
);
	import vsd_pkg::*;

	typedef struct packed {
		logic bit_value;
		logic last_bit;
	} decoded_t;

	decoded_t bits_due[$];

	logic [2:0]  klen;
	logic [2:0]  gen_count;
	logic [6:0]  gen_poly [4];
	logic [23:0] metric [64];
	logic        alive [64];
	logic [63:0] survivors [64];
	int          depth;

	function automatic int order_k();
		if (klen < 2) return 2;
		if (klen > 7) return 7;
		return klen;
	endfunction

	function automatic int order_n();
		if (gen_count < 2) return 2;
		if (gen_count > 4) return 4;
		return gen_count;
	endfunction

	task automatic clear_trellis();
		for (int i = 0; i < 64; i++) begin
			metric[i] = '0;
			alive[i] = 1'b0;
		end
		alive[0] = 1'b1;
		depth = 0;
	endtask

	task automatic add_compare_select(input logic signed [7:0] rx [4]);
		int k, n, states, smask, inbit, s, e, d;
		longint branch, total;
		logic [23:0] new_metric [64];
		logic        new_alive [64];
		logic [63:0] choice;
		logic [6:0]  word;
		k = order_k();
		n = order_n();
		states = 1 << (k - 1);
		smask = states - 1;
		choice = '0;
		for (int i = 0; i < 64; i++) begin
			new_metric[i] = '0;
			new_alive[i] = 1'b0;
		end
		for (int ns = 0; ns < states; ns++) begin
			inbit = (ns >> (k - 2)) & 1;
			for (int b = 0; b < 2; b++) begin
				s = ((ns << 1) & smask) | b;
				if (alive[s]) begin
					word = 7'((inbit << (k - 1)) | s);
					branch = 0;
					for (int g = 0; g < n; g++) begin
						e = (^(gen_poly[g] & word)) ? ONE_LEVEL : -ONE_LEVEL;
						d = int'(rx[g]) - e;
						branch += d * d;
					end
					total = longint'(metric[s]) + branch;
					if (total > longint'(METRIC_MAX)) total = longint'(METRIC_MAX);
					if (!new_alive[ns] || total < longint'(new_metric[ns])) begin
						new_alive[ns] = 1'b1;
						new_metric[ns] = 24'(total);
						choice[ns] = (b == 1);
					end
				end
			end
		end
		metric = new_metric;
		alive = new_alive;
		survivors[depth] = choice;
		depth++;
	endtask

	task automatic trace_back();
		int k, smask, best, st;
		logic found;
		decoded_t frame_bits [64];
		k = order_k();
		smask = (1 << (k - 1)) - 1;
		best = 0;
		found = 1'b0;
		for (int i = 0; i <= smask; i++)
			if (alive[i] && (!found || metric[i] < metric[best])) begin
				best = i;
				found = 1'b1;
			end
		st = best;
		for (int t = depth - 1; t >= 0; t--) begin
			frame_bits[t].bit_value = 1'((st >> (k - 2)) & 1);
			frame_bits[t].last_bit = (t == depth - 1);
			st = ((st << 1) & smask) | int'(survivors[t][st]);
		end
		for (int t = 0; t < depth; t++) bits_due.push_back(frame_bits[t]);
		clear_trellis();
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		logic signed [7:0] rx [4];
		if (!arst_n) begin
			klen = RST_CONSTRAINT;
			gen_count = RST_COUNT;
			gen_poly[0] = RST_GEN0;
			gen_poly[1] = RST_GEN1;
			gen_poly[2] = RST_GEN2;
			gen_poly[3] = RST_GEN3;
			clear_trellis();
			bits_due.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (bits_due.size() == 0) begin
					$display("%0t: unexpected output beat: bit %0b end %0b", $time,
						decoded_bit, frame_end);
					errors++;
				end else begin
					want = bits_due.pop_front();
					if (decoded_bit !== want.bit_value) begin
						$display("%0t: decoded_bit expected %0b actual %0b", $time,
							want.bit_value, decoded_bit);
						errors++;
					end
					if (frame_end !== want.last_bit) begin
						$display("%0t: frame_end expected %0b actual %0b", $time,
							want.last_bit, frame_end);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CONSTRAINT: klen = cfg_data[2:0];
					REG_COUNT:      gen_count = cfg_data[2:0];
					REG_GEN0:       gen_poly[0] = cfg_data;
					REG_GEN1:       gen_poly[1] = cfg_data;
					REG_GEN2:       gen_poly[2] = cfg_data;
					REG_GEN3:       gen_poly[3] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				rx[0] = soft_0;
				rx[1] = soft_1;
				rx[2] = soft_2;
				rx[3] = soft_3;
				if (depth < 64) add_compare_select(rx);
				if (last_step) trace_back();
			end
		end
		pending <= bits_due.size();
	end
endmodule

>>> test/testbench.sv
// Top of the soft Viterbi decoder testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps
module testbench;
	import vsd_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [6:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic signed [7:0] soft_0 = '0, soft_1 = '0, soft_2 = '0, soft_3 = '0;
	logic              last_step = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              decoded_bit;
	logic              frame_end;
	int                pending;
	int                errors;
	int                steps_sent = 0;
	logic              calm = 1'b0;
	logic              hold_due = 1'b0;

	always #5 clk = ~clk;

	viterbi_soft_decoder u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.soft_0(soft_0), .soft_1(soft_1), .soft_2(soft_2), .soft_3(soft_3),
		.last_step(last_step), .out_valid(out_valid), .out_ready(out_ready),
		.decoded_bit(decoded_bit), .frame_end(frame_end)
	);

	viterbi_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.soft_0(soft_0), .soft_1(soft_1), .soft_2(soft_2), .soft_3(soft_3),
		.last_step(last_step), .out_valid(out_valid), .out_ready(out_ready),
		.decoded_bit(decoded_bit), .frame_end(frame_end),
		.pending(pending), .errors(errors)
	);

	task automatic send_step(input logic signed [7:0] a, b, c, d, input logic mark);
		logic ok;
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		soft_0 <= a;
		soft_1 <= b;
		soft_2 <= c;
		soft_3 <= d;
		last_step <= mark;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		steps_sent++;
	endtask

	function automatic logic signed [7:0] noisy_sample();
		int v;
		if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
		v = ($urandom_range(0, 1) ? 32 : -32) + $urandom_range(0, 40) - 20;
		return 8'(v);
	endfunction

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_step(noisy_sample(), noisy_sample(), noisy_sample(), noisy_sample(),
				i == len - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [6:0] pick_poly();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	always @(posedge clk) begin
		int run;
		if (calm) begin
			out_ready <= 1'b1;
		end else if (hold_due) begin
			out_ready <= 1'b0;
			repeat (400) @(posedge clk);
			hold_due = 1'b0;
		end else begin
			run = $urandom_range(1, 15);
			out_ready <= 1'($urandom_range(0, 1));
			repeat (run - 1) @(posedge clk);
		end
	end

	initial begin
		logic [2:0] k_list [10] = '{3'd7, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5, 3'd1, 3'd6, 3'd7, 3'd2};
		logic [2:0] n_list [10] = '{3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd3, 3'd6};
		int phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b1);
		send_step(8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b0);
		send_step(8'sd32, -8'sd32, 8'sd0, 8'sd0, 1'b0);
		send_step(-8'sd32, 8'sd32, 8'sd127, -8'sd128, 1'b0);
		send_step(8'sd0, 8'sd127, -8'sd128, 8'sd32, 1'b1);
		for (int i = 0; i < 5; i++) send_step(8'sd0, 8'sd0, 8'sd0, 8'sd0, i == 4);
		drain();
		write_reg(REG_COUNT, 7'd4);
		write_reg(REG_GEN2, 7'd127);
		write_reg(REG_GEN3, 7'd0);
		send_step(-8'sd128, 8'sd127, -8'sd1, 8'sd64, 1'b0);
		send_step(8'sd127, -8'sd128, 8'sd1, -8'sd64, 1'b0);
		send_step(8'sd85, -8'sd86, 8'sd0, -8'sd1, 1'b1);

		phase = 0;
		while (steps_sent < 410) begin
			drain();
			write_reg(REG_CONSTRAINT, 7'(k_list[phase % 10]));
			write_reg(REG_COUNT, 7'(n_list[phase % 10]));
			write_reg(REG_GEN0, pick_poly());
			write_reg(REG_GEN1, pick_poly());
			write_reg(REG_GEN2, pick_poly());
			write_reg(REG_GEN3, pick_poly());
			if (phase == 1) begin
				hold_due = 1'b1;
				send_frame(6);
				send_frame(5);
			end
			if (phase == 2 || phase == 6) send_frame($urandom_range(64, 70));
			for (int f = 0; f < 4 && steps_sent < 410; f++) begin
				if (steps_sent > 350) calm = 1'b1;
				if ($urandom_range(0, 5) == 0)
					send_step(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
				send_frame($urandom_range(1, 12));
			end
			phase++;
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule
